// File: design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property p must hold at every rising clk edge outside reset.
`define ASSERT_CLK(label, p, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (p)) else $error(msg);

// After a, b must hold in the next cycle.
`define ASSERT_NEXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// File: design/cci_pkg.sv
// Package for the contour crossing interpolator: widths and defaults.
`default_nettype none
package cci_pkg;
    localparam int HEIGHT_BITS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 15;
endpackage
`default_nettype wire

// File: design/contour_crossing_interpolator.sv
// Top level of the contour crossing interpolator.
// Usage:
//  s_axis carries one grid step per request: tdata holds, from bit 0 up,
//  height_start, height_end, height_cross_a, height_cross_b; tuser holds
//  diagonal_step. m_axis returns one result per request: tdata holds
//  crossing_fraction (21 bits, Q.15) then saturated_low, zero padded.
//  cfg_valid/cfg_ready/cfg_data write contour_level; write only when idle.
//  Pipeline: 3 front stages plus one stage per quotient bit
//  (FRACTION_BITS+7) plus an output register; one request per cycle
//  while the output register is empty or being drained.
//  Reset clears all valid bits and sets contour_level to 0.
//  When m_axis_tready is low and the output register is full the whole
//  pipeline holds; s_axis_tready is high whenever the output register is
//  empty or being drained, so a stall loses and repeats nothing.
//  Zero denominators give 0 (straight) or 0.5 (diagonal).
`default_nettype none
module contour_crossing_interpolator #(
    parameter int HEIGHT_BITS   = cci_pkg::HEIGHT_BITS_DEF,
    parameter int FRACTION_BITS = cci_pkg::FRACTION_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [HEIGHT_BITS-1:0]   cfg_data,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // height_start, height_end, height_cross_a, height_cross_b
    input  wire logic [((4*HEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,
    // diagonal_step
    input  wire logic                     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // crossing_fraction, saturated_low
    output logic [((FRACTION_BITS+7+7)/8)*8-1:0] m_axis_tdata
);
    `include "assert_macros.svh"
    localparam int HB = HEIGHT_BITS;
    localparam int OB = FRACTION_BITS + 6;
    localparam int NB = HB + 5;   // numerator width
    localparam int DB = HB + 4;   // denominator width
    localparam int OW = ((FRACTION_BITS+7+7)/8)*8;
    localparam logic signed [OB-1:0] ONE  = OB'(1) << FRACTION_BITS;
    localparam logic signed [OB-1:0] HALF = OB'(1) << (FRACTION_BITS-1);
    localparam logic signed [OB-1:0] LOWV = {1'b1, {(OB-1){1'b0}}};

    logic signed [HB-1:0] level_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else if (cfg_valid)
            level_reg <= cfg_data;
    end

    logic out_v_reg;
    logic [OW-1:0] out_d_reg;
    logic en;
    assign en = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: differences, sums and shifted operands.
    logic v1_reg, dg1_reg;
    logic signed [DB-1:0] ls1_reg, le1_reg, es1_reg, t1_reg, s4_1_reg, e4_1_reg, d1_reg;
    logic signed [DB-1:0] l4_1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (en) v1_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic signed [DB-1:0] s, e, a, b, l;
            s = DB'(signed'(s_axis_tdata[HB-1:0]));
            e = DB'(signed'(s_axis_tdata[2*HB-1:HB]));
            a = DB'(signed'(s_axis_tdata[3*HB-1:2*HB]));
            b = DB'(signed'(s_axis_tdata[4*HB-1:3*HB]));
            l = DB'(level_reg);
            dg1_reg  <= s_axis_tuser;
            ls1_reg  <= l - s;
            le1_reg  <= l - e;
            es1_reg  <= e - s;
            t1_reg   <= s + e + a + b;
            s4_1_reg <= s <<< 2;
            e4_1_reg <= e <<< 2;
            l4_1_reg <= l <<< 2;
            d1_reg   <= e + s - a - b;
        end
    end

    // Stage 2: case selection, numerator and denominator.
    logic v2_reg, def2_reg;
    logic signed [OB-1:0] dflt2_reg;
    logic signed [NB-1:0] n2_reg;
    logic signed [DB-1:0] d2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic between;
            logic signed [NB-1:0] n;
            logic signed [DB-1:0] d;
            between = (ls1_reg >= 0 && le1_reg <= 0) || (ls1_reg <= 0 && le1_reg >= 0);
            if (!dg1_reg)
            begin
                n = NB'(ls1_reg);
                d = es1_reg;
            end
            else if (between)
            begin
                if (t1_reg >= l4_1_reg)
                begin
                    d = t1_reg - s4_1_reg;
                    n = NB'(ls1_reg) <<< 1;
                end
                else
                begin
                    d = t1_reg - e4_1_reg;
                    n = NB'(d) - (NB'(le1_reg) <<< 1);
                end
            end
            else
            begin
                d = d1_reg;
                n = NB'(d1_reg) + NB'(le1_reg);
            end
            n2_reg    <= n;
            d2_reg    <= d;
            def2_reg  <= d == '0;
            dflt2_reg <= dg1_reg ? HALF : '0;
        end
    end

    // Stage 3: register into divider, side data delayed alongside.
    logic dv, dover, dunder;
    logic [1:0] dtag;
    logic signed [OB-1:0] dq;
    cci_divider #(
        .NUM_BITS(NB), .DEN_BITS(DB), .FB(FRACTION_BITS), .QB(OB), .TAG_BITS(2)
    ) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2_reg),
        .num(n2_reg), .den(def2_reg ? DB'(1) : d2_reg),
        .tag_in({def2_reg, dflt2_reg[FRACTION_BITS-1]}),
        .out_valid(dv), .tag_out(dtag), .over_high(dover), .under_low(dunder),
        .quot(dq)
    );

    logic signed [OB-1:0] res;
    logic sat;
    always_comb
    begin
        sat = 1'b0;
        if (dtag[1])
            res = dtag[0] ? HALF : '0;
        else if (dover)
            res = ONE;
        else if (dunder)
        begin
            res = LOWV;
            sat = 1'b1;
        end
        else
            res = dq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_v_reg <= 1'b0;
        else if (en) out_v_reg <= dv;
    end
    always_ff @(posedge clk)
    begin
        if (en) out_d_reg <= OW'({sat, res});
    end
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;

    `ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed under stall")
    `ASSERT_CLK(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
    `ASSERT_CLK(a_sat, !(m_axis_tvalid && m_axis_tdata[OB] && m_axis_tdata[OB-1:0] != LOWV), "sat flag with non-lowest value")
endmodule
`default_nettype wire

// File: design/cci_divider.sv
// Pipelined restoring divider: floor(num * 2^FB / den), one quotient bit per stage.
`default_nettype none
module cci_divider #(
    parameter int NUM_BITS = 29,
    parameter int DEN_BITS = 28,
    parameter int FB       = 15,
    parameter int QB       = 21,
    parameter int TAG_BITS = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic signed [NUM_BITS-1:0] num,
    input  wire logic signed [DEN_BITS-1:0] den,
    input  wire logic [TAG_BITS-1:0]        tag_in,
    output logic                            out_valid,
    output logic [TAG_BITS-1:0]             tag_out,
    output logic                            over_high,
    output logic                            under_low,
    output logic signed [QB-1:0]            quot
);
    // Magnitude quotient needs NUM_BITS+FB bits; we keep QB+1 low bits and
    // detect larger magnitudes by comparing the dividend with den << QK.
    localparam int MB = NUM_BITS + FB;        // dividend magnitude width
    localparam int QK = QB + 1;               // quotient bits computed
    localparam int DB = DEN_BITS;
    localparam int ST = QK;                   // stages

    logic          v_reg    [ST+1];
    logic [TAG_BITS-1:0] t_reg [ST+1];
    logic [MB-1:0] r_reg    [ST+1];           // partial remainder / dividend
    logic [DB-1:0] d_reg    [ST+1];
    logic [QK-1:0] q_reg    [ST+1];
    logic          neg_reg  [ST+1];
    logic          big_reg  [ST+1];

    logic [NUM_BITS-1:0] an;
    logic [DB-1:0]       ad;
    logic [MB-1:0]       m0;

    always_comb
    begin
        an = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
        ad = den[DB-1] ? DB'(-den) : DB'(den);
        m0 = {an, {FB{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= ST; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= ST; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]   <= tag_in;
            r_reg[0]   <= m0;
            d_reg[0]   <= ad;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_BITS-1] ^ den[DB-1];
            // quotient >= 2^QK iff m0 >= ad << QK
            big_reg[0] <= (MB+QK+1)'(m0) >= ((MB+QK+1)'(ad) << QK);
            for (int i = 1; i <= ST; i++)
            begin
                logic [MB+QK:0] sh;
                sh = (MB+QK+1)'(d_reg[i-1]) << (QK - i);
                t_reg[i]   <= t_reg[i-1];
                d_reg[i]   <= d_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                big_reg[i] <= big_reg[i-1];
                if ((MB+QK+1)'(r_reg[i-1]) >= sh)
                begin
                    r_reg[i] <= MB'((MB+QK+1)'(r_reg[i-1]) - sh);
                    q_reg[i] <= q_reg[i-1] | (QK'(1) << (QK - i));
                end
                else
                begin
                    r_reg[i] <= r_reg[i-1];
                    q_reg[i] <= q_reg[i-1];
                end
            end
        end
    end

    // Final sign, floor and range handling.
    logic [QK:0]  mag;
    logic         nz;
    logic signed [QK+1:0] sq;
    localparam logic signed [QK+1:0] ONE_S = (QK+2)'(1) << FB;
    localparam logic signed [QK+1:0] LOW_S = -((QK+2)'(1) << (QB-1));
    always_comb
    begin
        nz  = r_reg[ST] != '0;
        mag = {1'b0, q_reg[ST]} + (QK+1)'(neg_reg[ST] && nz);
        sq  = neg_reg[ST] ? -(QK+2)'(mag) : (QK+2)'(mag);
        out_valid = v_reg[ST];
        tag_out   = t_reg[ST];
        over_high = big_reg[ST] ? !neg_reg[ST] : (sq > ONE_S);
        under_low = big_reg[ST] ? neg_reg[ST] : (sq < LOW_S);
        quot      = QB'(sq);
    end
endmodule
`default_nettype wire
